FILE: rtl/fcam_pkg.sv
// ----------------------------------------------------------------------------
// fcam_pkg
// Shared constants, codes and types of the fly camera core: fixed-point angle
// constants, CORDIC arctangent table, operation codes and register indexes.
// ----------------------------------------------------------------------------
package fcam_pkg;

  localparam int POS_WIDTH_DEF  = 32;
  localparam int UNIT_WIDTH_DEF = 16;

  // Angles in Q9.16 degrees
  localparam int DEG89  = 5832704;
  localparam int DEG90  = 5898240;
  localparam int DEG180 = 11796480;
  localparam int DEG360 = 23592960;

  // CORDIC start gain at Q2.30
  localparam int CORDIC_K = 652032874;

  localparam int CRD_W   = 34;
  localparam int ANG_W   = 26;
  localparam int YAW_W   = 25;
  localparam int PITCH_W = 24;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int WIDE_W = 67;
  localparam int ACC_W  = 100;
  localparam int WACC_W = 40;

  localparam logic [3:0] CRD_LAST_STEP = 4'd15;
  localparam logic [3:0] WRAP_TOP      = 4'd13;
  localparam longint     WRAP_BIAS     = longint'(DEG360) * 64'sd8192;

  typedef enum logic [1:0] {
    OP_MOVE = 2'd0,
    OP_TURN = 2'd1,
    OP_VIEW = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_TURN_SPEED  = 3'd1;
  localparam logic [2:0] CFG_START_X     = 3'd2;
  localparam logic [2:0] CFG_START_Y     = 3'd3;
  localparam logic [2:0] CFG_START_Z     = 3'd4;
  localparam logic [2:0] CFG_START_YAW   = 3'd5;
  localparam logic [2:0] CFG_START_PITCH = 3'd6;

  localparam logic [15:0] MOVE_SPEED_RST = 16'd1280;
  localparam logic [15:0] TURN_SPEED_RST = 16'd256;

  localparam logic [1:0] ROW_LAST = 2'd3;
  localparam logic [1:0] ROW_FRONT = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } crd_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [CRD_W-1:0] cos_v;
    logic signed [CRD_W-1:0] sin_v;
  } crd_rsp_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [3:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      4'd0:    r = ANG_W'(2949120);
      4'd1:    r = ANG_W'(1740967);
      4'd2:    r = ANG_W'(919879);
      4'd3:    r = ANG_W'(466945);
      4'd4:    r = ANG_W'(234379);
      4'd5:    r = ANG_W'(117304);
      4'd6:    r = ANG_W'(58666);
      4'd7:    r = ANG_W'(29335);
      4'd8:    r = ANG_W'(14668);
      4'd9:    r = ANG_W'(7334);
      4'd10:   r = ANG_W'(3667);
      4'd11:   r = ANG_W'(1833);
      4'd12:   r = ANG_W'(917);
      4'd13:   r = ANG_W'(458);
      4'd14:   r = ANG_W'(229);
      default: r = ANG_W'(115);
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/fcam_mul.sv
// ----------------------------------------------------------------------------
// fcam_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fcam_mul (
  input  logic                                clk,
  input  logic signed [fcam_pkg::MUL_W-1:0]   a,
  input  logic signed [fcam_pkg::MUL_W-1:0]   b,
  output logic signed [fcam_pkg::PROD_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

FILE: rtl/fcam_cordic.sv
// ----------------------------------------------------------------------------
// fcam_cordic
// Iterative rotation-mode CORDIC: sine and cosine of a Q9.16 degree angle at
// Q2.30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module fcam_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  fcam_pkg::crd_req_t  req,
  output fcam_pkg::crd_rsp_t  rsp
);

  logic signed [fcam_pkg::CRD_W-1:0] x_r, y_r;
  logic signed [fcam_pkg::ANG_W-1:0] z_r;
  logic [3:0]                        it_r;
  logic                              run_r, neg_r, done_r;

  logic signed [fcam_pkg::ANG_W-1:0] z_init;
  logic                              neg_init;
  logic signed [fcam_pkg::CRD_W-1:0] dx, dy;
  logic signed [fcam_pkg::ANG_W-1:0] da;

  // Fold angles beyond a quarter turn back and flip the results
  always_comb begin
    z_init   = req.angle;
    neg_init = 1'b0;
    if (req.angle > fcam_pkg::DEG90) begin
      z_init   = fcam_pkg::ANG_W'(req.angle - fcam_pkg::DEG180);
      neg_init = 1'b1;
    end else if (req.angle < -fcam_pkg::DEG90) begin
      z_init   = fcam_pkg::ANG_W'(req.angle + fcam_pkg::DEG180);
      neg_init = 1'b1;
    end
  end

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign da = fcam_pkg::atan_step(it_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        x_r   <= fcam_pkg::CRD_W'(fcam_pkg::CORDIC_K);
        y_r   <= '0;
        z_r   <= z_init;
        neg_r <= neg_init;
        it_r  <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - da;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + da;
        end
        it_r <= it_r + 4'd1;
        if (it_r == fcam_pkg::CRD_LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = neg_r ? -x_r : x_r;
  assign rsp.sin_v = neg_r ? -y_r : y_r;

endmodule

FILE: rtl/fly_camera_pose_and_view_matrix_core.sv
// ----------------------------------------------------------------------------
// Fly camera pose and view matrix core
// Turn and load: two 16-step CORDIC runs, 14-step yaw wrap, shared multiplier.
// One request at a time: a new request is taken only while the core is idle;
// synchronous active-low reset restores the default pose.
// ----------------------------------------------------------------------------
module fly_camera_pose_and_view_matrix_core #(
  parameter int POS_WIDTH  = fcam_pkg::POS_WIDTH_DEF,
  parameter int UNIT_WIDTH = fcam_pkg::UNIT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic               in_key_forward,
  input  logic               in_key_back,
  input  logic               in_key_rightward,
  input  logic               in_key_leftward,
  input  logic signed [15:0] in_x_change,
  input  logic signed [15:0] in_y_change,
  input  logic [15:0]        in_delta_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int UF = UNIT_WIDTH - 2;
  localparam int WW = fcam_pkg::WIDE_W;
  localparam int AW = fcam_pkg::ACC_W;

  localparam logic signed [WW-1:0] POS_MAX = (67'sd1 <<< (POS_WIDTH - 1)) - 67'sd1;
  localparam logic signed [WW-1:0] POS_MIN = -POS_MAX - 67'sd1;
  localparam logic signed [WW-1:0] U_MAX   = (67'sd1 <<< (UNIT_WIDTH - 1)) - 67'sd1;
  localparam logic signed [WW-1:0] U_MIN   = -U_MAX - 67'sd1;
  localparam logic signed [AW-1:0] S32_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] S32_MIN = -S32_MAX - AW'(1);
  localparam logic signed [AW-1:0] TR_HALF = AW'(1) <<< (UF - 1);
  localparam logic signed [UNIT_WIDTH-1:0] U_ONE = UNIT_WIDTH'(1) <<< UF;

  typedef enum logic [3:0] {
    S_IDLE, S_MV_SD, S_MV, S_TN_SD, S_TN_P, S_TN_Y, S_LOAD, S_WRAP,
    S_CRD_YAW, S_CRD_PITCH, S_VEC, S_VW_MUL, S_VW_OUT, S_VW_WAIT
  } state_t;

  // ---------------- helpers ----------------
  function automatic logic signed [WW-1:0] rnd(input logic signed [WW-1:0] v, input int sh);
    if (sh <= 0) return v;
    return (v + (67'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [WW-1:0] v);
    if (v > POS_MAX) return POS_WIDTH'(POS_MAX);
    if (v < POS_MIN) return POS_WIDTH'(POS_MIN);
    return POS_WIDTH'(v);
  endfunction

  function automatic logic signed [UNIT_WIDTH-1:0] sat_unit(input logic signed [WW-1:0] v);
    if (v > U_MAX) return UNIT_WIDTH'(U_MAX);
    if (v < U_MIN) return UNIT_WIDTH'(U_MIN);
    return UNIT_WIDTH'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if (v > S32_MAX) return 32'(S32_MAX);
    if (v < S32_MIN) return 32'(S32_MIN);
    return 32'(v);
  endfunction

  function automatic logic signed [fcam_pkg::PITCH_W-1:0] clamp_pitch(
    input logic signed [WW-1:0] v);
    if (v > fcam_pkg::DEG89) return fcam_pkg::PITCH_W'(fcam_pkg::DEG89);
    if (v < -fcam_pkg::DEG89) return fcam_pkg::PITCH_W'(-fcam_pkg::DEG89);
    return fcam_pkg::PITCH_W'(v);
  endfunction

  function automatic logic signed [fcam_pkg::WACC_W-1:0] wrap_pre(
    input logic signed [WW-1:0] v);
    if (v < 0) return fcam_pkg::WACC_W'(v + fcam_pkg::WRAP_BIAS);
    return fcam_pkg::WACC_W'(v);
  endfunction

  function automatic logic signed [31:0] elem(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] q;
    if (UF >= 16) q = rnd(v, UF - 16);
    else q = v <<< (16 - UF);
    return sat32(AW'(q));
  endfunction

  // ---------------- registers ----------------
  state_t     state_r;
  logic       phase_r;
  logic [2:0] idx_r;
  logic [1:0] k_r;
  logic [1:0] row_r;
  logic [3:0] wk_r;

  logic [3:0]        keys_r;
  logic signed [15:0] xch_r, ych_r;
  logic [15:0]        dt_r;
  logic [31:0]        sd_r;
  logic signed [fcam_pkg::WACC_W-1:0] wacc_r;
  logic signed [AW-1:0] acc_r;

  logic signed [POS_WIDTH-1:0]  pos_r [3];
  logic signed [fcam_pkg::YAW_W-1:0]   yaw_r;
  logic signed [fcam_pkg::PITCH_W-1:0] pitch_r;
  logic signed [UNIT_WIDTH-1:0] front_r [3];
  logic signed [UNIT_WIDTH-1:0] right_r [3];
  logic signed [UNIT_WIDTH-1:0] up_r [3];
  logic signed [fcam_pkg::CRD_W-1:0] cy_r, sy_r, cp_r, sp_r;

  logic [15:0]        move_speed_r, turn_speed_r;
  logic signed [31:0] start_pos_r [3];
  logic signed [fcam_pkg::YAW_W-1:0]   start_yaw_r;
  logic signed [fcam_pkg::PITCH_W-1:0] start_pitch_r;

  logic               out_valid_r, out_last_r;
  logic [1:0]         out_row_r;
  logic signed [31:0] out_c0_r, out_c1_r, out_c2_r, out_c3_r;

  // ---------------- shared units ----------------
  logic signed [fcam_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [fcam_pkg::PROD_W-1:0] mul_p;
  fcam_pkg::crd_req_t crd_req;
  fcam_pkg::crd_rsp_t crd_rsp;

  fcam_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));
  fcam_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(crd_req), .rsp(crd_rsp));

  assign crd_req.start = ((state_r == S_CRD_YAW) || (state_r == S_CRD_PITCH)) && !phase_r;
  assign crd_req.angle = (state_r == S_CRD_YAW) ? fcam_pkg::ANG_W'(yaw_r)
                                                : fcam_pkg::ANG_W'(pitch_r);

  // ---------------- datapath selects ----------------
  logic signed [UNIT_WIDTH-1:0] mv_comp, vw_comp;
  logic signed [63:0]           vw_p64;
  logic signed [WW-1:0]         prod_w, mv_d, tn_d;
  logic signed [UNIT_WIDTH-1:0] vec_d;
  logic signed [AW-1:0]         vw_term, tr_shift;
  logic signed [fcam_pkg::WACC_W-1:0] wrap_cand, wrap_red;
  logic signed [WW-1:0]         rv [3];
  logic signed [31:0]           row_el [3];

  always_comb begin
    mv_comp = k_r[1] ? right_r[idx_r[1:0]] : front_r[idx_r[1:0]];
    case (row_r)
      2'd0:    vw_comp = right_r[idx_r[2:1]];
      2'd1:    vw_comp = up_r[idx_r[2:1]];
      default: vw_comp = front_r[idx_r[2:1]];
    endcase
    vw_p64  = 64'(pos_r[idx_r[2:1]]);
    prod_w  = WW'(mul_p);
    mv_d    = rnd(prod_w, UF + 8);
    tn_d    = rnd(prod_w, 12);
    vec_d   = sat_unit(rnd(prod_w, 60 - UF));
    vw_term = idx_r[0] ? (AW'(mul_p) <<< 32) : AW'(mul_p);
    tr_shift = (acc_r + TR_HALF) >>> UF;
    wrap_cand = fcam_pkg::WACC_W'(fcam_pkg::DEG360) <<< wk_r;
    wrap_red  = (wacc_r >= wrap_cand) ? (wacc_r - wrap_cand) : wacc_r;
    for (int j = 0; j < 3; j++) begin
      case (row_r)
        2'd0:    rv[j] = WW'(right_r[j]);
        2'd1:    rv[j] = WW'(up_r[j]);
        default: rv[j] = -WW'(front_r[j]);
      endcase
      row_el[j] = elem(rv[j]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MV_SD: begin
        mul_a = fcam_pkg::MUL_W'(move_speed_r);
        mul_b = fcam_pkg::MUL_W'(dt_r);
      end
      S_TN_SD: begin
        mul_a = fcam_pkg::MUL_W'(turn_speed_r);
        mul_b = fcam_pkg::MUL_W'(dt_r);
      end
      S_MV: begin
        mul_a = fcam_pkg::MUL_W'(mv_comp);
        mul_b = fcam_pkg::MUL_W'(sd_r);
      end
      S_TN_P: begin
        mul_a = fcam_pkg::MUL_W'(ych_r);
        mul_b = fcam_pkg::MUL_W'(sd_r);
      end
      S_TN_Y: begin
        mul_a = fcam_pkg::MUL_W'(xch_r);
        mul_b = fcam_pkg::MUL_W'(sd_r);
      end
      S_VEC: begin
        case (idx_r)
          3'd0: begin
            mul_a = fcam_pkg::MUL_W'(sy_r);
            mul_b = fcam_pkg::MUL_W'(cp_r);
          end
          3'd1: begin
            mul_a = fcam_pkg::MUL_W'(-cy_r);
            mul_b = fcam_pkg::MUL_W'(cp_r);
          end
          3'd2: begin
            mul_a = fcam_pkg::MUL_W'(-sy_r);
            mul_b = fcam_pkg::MUL_W'(sp_r);
          end
          default: begin
            mul_a = fcam_pkg::MUL_W'(cy_r);
            mul_b = fcam_pkg::MUL_W'(sp_r);
          end
        endcase
      end
      S_VW_MUL: begin
        mul_a = idx_r[0] ? fcam_pkg::MUL_W'(vw_p64 >>> 32)
                         : fcam_pkg::MUL_W'(vw_p64[31:0]);
        mul_b = fcam_pkg::MUL_W'(vw_comp);
      end
      default: ;
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r  <= fcam_pkg::MOVE_SPEED_RST;
      turn_speed_r  <= fcam_pkg::TURN_SPEED_RST;
      start_pos_r[0] <= '0;
      start_pos_r[1] <= '0;
      start_pos_r[2] <= '0;
      start_yaw_r   <= '0;
      start_pitch_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcam_pkg::CFG_MOVE_SPEED:  move_speed_r   <= cfg_data[15:0];
        fcam_pkg::CFG_TURN_SPEED:  turn_speed_r   <= cfg_data[15:0];
        fcam_pkg::CFG_START_X:     start_pos_r[0] <= cfg_data;
        fcam_pkg::CFG_START_Y:     start_pos_r[1] <= cfg_data;
        fcam_pkg::CFG_START_Z:     start_pos_r[2] <= cfg_data;
        fcam_pkg::CFG_START_YAW:   start_yaw_r    <= cfg_data[fcam_pkg::YAW_W-1:0];
        fcam_pkg::CFG_START_PITCH: start_pitch_r  <= cfg_data[fcam_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      idx_r       <= '0;
      k_r         <= '0;
      row_r       <= '0;
      wk_r        <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < 3; j++) pos_r[j] <= '0;
      yaw_r      <= '0;
      pitch_r    <= '0;
      front_r[0] <= '0;
      front_r[1] <= '0;
      front_r[2] <= -U_ONE;
      right_r[0] <= U_ONE;
      right_r[1] <= '0;
      right_r[2] <= '0;
      up_r[0]    <= '0;
      up_r[1]    <= U_ONE;
      up_r[2]    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          phase_r <= 1'b0;
          idx_r   <= '0;
          k_r     <= '0;
          row_r   <= '0;
          acc_r   <= '0;
          if (in_valid) begin
            keys_r <= {in_key_leftward, in_key_rightward, in_key_back, in_key_forward};
            xch_r  <= in_x_change;
            ych_r  <= in_y_change;
            dt_r   <= in_delta_time;
            unique case (fcam_pkg::op_t'(in_op))
              fcam_pkg::OP_MOVE: state_r <= S_MV_SD;
              fcam_pkg::OP_TURN: state_r <= S_TN_SD;
              fcam_pkg::OP_VIEW: state_r <= S_VW_MUL;
              fcam_pkg::OP_LOAD: state_r <= S_LOAD;
              default:           state_r <= S_IDLE;
            endcase
          end
        end

        S_MV_SD: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            sd_r    <= mul_p[31:0];
            state_r <= S_MV;
          end
        end

        S_MV: begin
          if (!keys_r[k_r]) begin
            // skip a key that is not held
            idx_r <= '0;
            if (k_r == 2'd3) state_r <= S_IDLE;
            else k_r <= k_r + 2'd1;
          end else if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            pos_r[idx_r[1:0]] <= sat_pos(WW'(pos_r[idx_r[1:0]]) + (k_r[0] ? -mv_d : mv_d));
            if (idx_r == 3'd2) begin
              idx_r <= '0;
              if (k_r == 2'd3) state_r <= S_IDLE;
              else k_r <= k_r + 2'd1;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end

        S_TN_SD: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            sd_r    <= mul_p[31:0];
            state_r <= S_TN_P;
          end
        end

        S_TN_P: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            pitch_r <= clamp_pitch(WW'(pitch_r) + tn_d);
            state_r <= S_TN_Y;
          end
        end

        S_TN_Y: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            wacc_r  <= wrap_pre(WW'(yaw_r) + tn_d + WW'(fcam_pkg::DEG180));
            wk_r    <= fcam_pkg::WRAP_TOP;
            state_r <= S_WRAP;
          end
        end

        S_LOAD: begin
          for (int j = 0; j < 3; j++) pos_r[j] <= sat_pos(WW'(start_pos_r[j]));
          pitch_r <= clamp_pitch(WW'(start_pitch_r));
          wacc_r  <= wrap_pre(WW'(start_yaw_r) + WW'(fcam_pkg::DEG180));
          wk_r    <= fcam_pkg::WRAP_TOP;
          state_r <= S_WRAP;
        end

        S_WRAP: begin
          // restoring reduction by 360 degrees times a falling power of two
          wacc_r <= wrap_red;
          if (wk_r == 4'd0) begin
            yaw_r   <= fcam_pkg::YAW_W'(wrap_red - fcam_pkg::WACC_W'(fcam_pkg::DEG180));
            phase_r <= 1'b0;
            state_r <= S_CRD_YAW;
          end else begin
            wk_r <= wk_r - 4'd1;
          end
        end

        S_CRD_YAW: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (crd_rsp.done) begin
            cy_r    <= crd_rsp.cos_v;
            sy_r    <= crd_rsp.sin_v;
            phase_r <= 1'b0;
            state_r <= S_CRD_PITCH;
          end
        end

        S_CRD_PITCH: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (crd_rsp.done) begin
            cp_r       <= crd_rsp.cos_v;
            sp_r       <= crd_rsp.sin_v;
            right_r[0] <= sat_unit(rnd(WW'(cy_r), 30 - UF));
            right_r[1] <= '0;
            right_r[2] <= sat_unit(rnd(WW'(sy_r), 30 - UF));
            front_r[1] <= sat_unit(rnd(WW'(crd_rsp.sin_v), 30 - UF));
            up_r[1]    <= sat_unit(rnd(WW'(crd_rsp.cos_v), 30 - UF));
            phase_r    <= 1'b0;
            idx_r      <= '0;
            state_r    <= S_VEC;
          end
        end

        S_VEC: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            case (idx_r)
              3'd0:    front_r[0] <= vec_d;
              3'd1:    front_r[2] <= vec_d;
              3'd2:    up_r[0]    <= vec_d;
              default: up_r[2]    <= vec_d;
            endcase
            if (idx_r == 3'd3) state_r <= S_IDLE;
            else idx_r <= idx_r + 3'd1;
          end
        end

        S_VW_MUL: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            acc_r <= (row_r == fcam_pkg::ROW_FRONT) ? acc_r + vw_term : acc_r - vw_term;
            if (idx_r == 3'd5) begin
              idx_r   <= '0;
              state_r <= S_VW_OUT;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end

        S_VW_OUT: begin
          out_valid_r <= 1'b1;
          out_row_r   <= row_r;
          out_c0_r    <= row_el[0];
          out_c1_r    <= row_el[1];
          out_c2_r    <= row_el[2];
          out_c3_r    <= sat32(tr_shift);
          out_last_r  <= 1'b0;
          state_r     <= S_VW_WAIT;
        end

        S_VW_WAIT: begin
          if (out_ready) begin
            if (row_r == fcam_pkg::ROW_FRONT) begin
              // constant bottom row follows at once
              row_r      <= fcam_pkg::ROW_LAST;
              out_row_r  <= fcam_pkg::ROW_LAST;
              out_c0_r   <= '0;
              out_c1_r   <= '0;
              out_c2_r   <= '0;
              out_c3_r   <= 32'sd65536;
              out_last_r <= 1'b1;
            end else if (row_r == fcam_pkg::ROW_LAST) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_valid_r <= 1'b0;
              row_r       <= row_r + 2'd1;
              idx_r       <= '0;
              phase_r     <= 1'b0;
              acc_r       <= '0;
              state_r     <= S_VW_MUL;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col0      = out_c0_r;
  assign out_col1      = out_c1_r;
  assign out_col2      = out_c2_r;
  assign out_col3      = out_c3_r;
  assign out_last      = out_last_r;

  // ---------------- assertions ----------------
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a matrix row is pending");

  a_pitch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= fcam_pkg::DEG89) && (pitch_r >= -fcam_pkg::DEG89))
    else $error("pitch outside +-89 degrees");

  a_yaw_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (yaw_r >= -fcam_pkg::DEG180) && (yaw_r < fcam_pkg::DEG180))
    else $error("yaw not wrapped");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_row_index == fcam_pkg::ROW_LAST))
    else $error("last flag on a row other than the bottom row");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Fly camera core testbench
// Drives move, turn, view and load requests with random idling on both sides.
// An in-bench pose model predicts every view matrix row, and each row is
// checked field by field. Configuration changes between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    fcam_pkg::op_t     op;
    logic [3:0]        keys;  // forward, back, rightward, leftward
    logic signed [15:0] xc;
    logic signed [15:0] yc;
    logic [15:0]       dt;
  } cam_req_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] col [4];
    logic        last;
  } view_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic in_key_forward = 1'b0, in_key_back = 1'b0;
  logic in_key_rightward = 1'b0, in_key_leftward = 1'b0;
  logic signed [15:0] in_x_change = '0, in_y_change = '0;
  logic [15:0] in_delta_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col0, out_col1, out_col2, out_col3;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  fly_camera_pose_and_view_matrix_core dut (.*);

  cam_req_t  pending_q[$];
  view_row_t rows_q[$];
  int  errors = 0;
  bit  calm = 1'b0;          // no idling in the final part
  bit  long_stall_go = 1'b0;
  int  cycles = 0;

  // pose model
  longint pos [3];
  longint yaw, pitch;
  longint fv [3], rv [3], uv [3];
  longint cfg_val [7];

  function automatic longint rsh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint wrap_yaw(longint y);
    longint r;
    r = (y + fcam_pkg::DEG180) % fcam_pkg::DEG360;
    if (r < 0) r += fcam_pkg::DEG360;
    return r - fcam_pkg::DEG180;
  endfunction

  function automatic longint clamp_pitch(longint p);
    return p > fcam_pkg::DEG89 ? fcam_pkg::DEG89
                               : (p < -fcam_pkg::DEG89 ? -fcam_pkg::DEG89 : p);
  endfunction

  function automatic void sin_cos(input longint a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit neg;
    x = fcam_pkg::CORDIC_K; y = 0; z = a; neg = 0;
    if (z > fcam_pkg::DEG90) begin z -= fcam_pkg::DEG180; neg = 1; end
    else if (z < -fcam_pkg::DEG90) begin z += fcam_pkg::DEG180; neg = 1; end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= fcam_pkg::atan_step(4'(i)); end
      else begin x += dx; y -= dy; z += fcam_pkg::atan_step(4'(i)); end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic void refresh_axes();
    longint cy, sy, cp, sp;
    sin_cos(yaw, cy, sy);
    sin_cos(pitch, cp, sp);
    fv[0] = sat(rsh(sy * cp, 46), 16);
    fv[1] = sat(rsh(sp, 16), 16);
    fv[2] = sat(rsh(-(cy * cp), 46), 16);
    rv[0] = sat(rsh(cy, 16), 16);
    rv[1] = 0;
    rv[2] = sat(rsh(sy, 16), 16);
    uv[0] = sat(rsh(-(sy * sp), 46), 16);
    uv[1] = sat(rsh(cp, 16), 16);
    uv[2] = sat(rsh(cy * sp, 46), 16);
  endfunction

  function automatic logic [31:0] shift_elem(longint v);
    return 32'(sat(v * 4, 32));
  endfunction

  function automatic logic [31:0] eye_term(longint v0, longint v1, longint v2, bit negate);
    longint s;
    s = pos[0] * v0 + pos[1] * v1 + pos[2] * v2;
    if (negate) s = -s;
    return 32'(sat(rsh(s, 14), 32));
  endfunction

  function automatic void pose_reset();
    cfg_val = '{1280, 256, 0, 0, 0, 0, 0};
    pos = '{0, 0, 0};
    yaw = 0; pitch = 0;
    fv = '{0, 0, -16384};
    rv = '{16384, 0, 0};
    uv = '{0, 16384, 0};
  endfunction

  function automatic void apply_request(cam_req_t r);
    longint d, dp, dy;
    view_row_t row;
    case (r.op)
      fcam_pkg::OP_MOVE: begin
        for (int k = 0; k < 4; k++) begin
          if (!r.keys[k]) continue;
          for (int i = 0; i < 3; i++) begin
            d = rsh((k < 2 ? fv[i] : rv[i]) * cfg_val[fcam_pkg::CFG_MOVE_SPEED]
                    * longint'(r.dt), 22);
            pos[i] = sat(pos[i] + ((k & 1) ? -d : d), 32);
          end
        end
      end
      fcam_pkg::OP_TURN: begin
        dp = rsh(longint'(r.yc) * cfg_val[fcam_pkg::CFG_TURN_SPEED] * longint'(r.dt), 12);
        dy = rsh(longint'(r.xc) * cfg_val[fcam_pkg::CFG_TURN_SPEED] * longint'(r.dt), 12);
        pitch = clamp_pitch(pitch + dp);
        yaw = wrap_yaw(yaw + dy);
        refresh_axes();
      end
      fcam_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) pos[i] = cfg_val[fcam_pkg::CFG_START_X + i];
        yaw = wrap_yaw(cfg_val[fcam_pkg::CFG_START_YAW]);
        pitch = clamp_pitch(cfg_val[fcam_pkg::CFG_START_PITCH]);
        refresh_axes();
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          row.row = 2'(i);
          row.last = (2'(i) == fcam_pkg::ROW_LAST);
          if (2'(i) == fcam_pkg::ROW_LAST) begin
            row.col = '{0, 0, 0, 32'h10000};
          end else if (i == 0) begin
            for (int j = 0; j < 3; j++) row.col[j] = shift_elem(rv[j]);
            row.col[3] = eye_term(rv[0], rv[1], rv[2], 1);
          end else if (i == 1) begin
            for (int j = 0; j < 3; j++) row.col[j] = shift_elem(uv[j]);
            row.col[3] = eye_term(uv[0], uv[1], uv[2], 1);
          end else begin
            for (int j = 0; j < 3; j++) row.col[j] = shift_elem(-fv[j]);
            row.col[3] = eye_term(fv[0], fv[1], fv[2], 0);
          end
          rows_q.push_back(row);
        end
      end
    endcase
  endfunction

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    cam_req_t r;
    logic nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt = in_valid;
      if (in_valid && in_ready) begin
        r.op = fcam_pkg::op_t'(in_op);
        r.keys = {in_key_leftward, in_key_rightward, in_key_back, in_key_forward};
        r.xc = in_x_change; r.yc = in_y_change; r.dt = in_delta_time;
        apply_request(r);
        nxt = 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 18);
      end
      if (!nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          r = pending_q.pop_front();
          in_op <= r.op;
          {in_key_leftward, in_key_rightward, in_key_back, in_key_forward} <= r.keys;
          in_x_change <= r.xc; in_y_change <= r.yc; in_delta_time <= r.dt;
          nxt = 1'b1;
        end
      end
      in_valid <= nxt;
    end
  end

  // monitor
  int stall_left = 0;
  int long_count = 0;
  always @(posedge clk) begin
    view_row_t e;
    logic [31:0] got [4];
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_col0, out_col1, out_col2, out_col3};
        if (rows_q.size() == 0) begin
          $display("%0t: unexpected row %0d", $time, out_row_index);
          errors++;
        end else begin
          e = rows_q.pop_front();
          if (out_row_index !== e.row) begin
            $display("%0t: row_index exp %0d got %0d", $time, e.row, out_row_index);
            errors++;
          end
          for (int j = 0; j < 4; j++)
            if (got[j] !== e.col[j]) begin
              $display("%0t: row %0d col%0d exp %h got %h", $time, e.row, j, e.col[j], got[j]);
              errors++;
            end
          if (out_last !== e.last) begin
            $display("%0t: last exp %0b got %0b", $time, e.last, out_last);
            errors++;
          end
        end
      end
      if (long_stall_go && long_count < 400) begin
        long_count++;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx) inside
      fcam_pkg::CFG_MOVE_SPEED, fcam_pkg::CFG_TURN_SPEED:
        cfg_val[idx] = longint'(val[15:0]);
      fcam_pkg::CFG_START_X, fcam_pkg::CFG_START_Y, fcam_pkg::CFG_START_Z:
        cfg_val[idx] = longint'($signed(val));
      fcam_pkg::CFG_START_YAW: cfg_val[idx] = longint'($signed(val[24:0]));
      fcam_pkg::CFG_START_PITCH: cfg_val[idx] = longint'($signed(val[23:0]));
      default: ;  // out of range: drop
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || rows_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic push(fcam_pkg::op_t op, logic [3:0] keys, int xc, int yc, int dt);
    cam_req_t r;
    r.op = op; r.keys = keys; r.xc = 16'(xc); r.yc = 16'(yc); r.dt = 16'(dt);
    pending_q.push_back(r);
  endtask

  task automatic push_random(int n);
    cam_req_t r;
    int w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      r.op = w < 35 ? fcam_pkg::OP_MOVE
                    : (w < 65 ? fcam_pkg::OP_TURN
                              : (w < 92 ? fcam_pkg::OP_VIEW : fcam_pkg::OP_LOAD));
      r.keys = 4'($urandom);
      r.xc = 16'($urandom);
      r.yc = 16'($urandom);
      r.dt = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
      pending_q.push_back(r);
    end
  endtask

  initial begin
    pose_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // start pose beyond the pitch limit and outside the yaw range
    write_reg(fcam_pkg::CFG_START_X, 32'h7fff_ffff);
    write_reg(fcam_pkg::CFG_START_Y, 32'h8000_0000);
    write_reg(fcam_pkg::CFG_START_Z, 32'h0001_2345);
    write_reg(fcam_pkg::CFG_START_YAW, 32'h0100_0000);
    write_reg(fcam_pkg::CFG_START_PITCH, 32'h007f_ffff);
    write_reg(3'd7, 32'hffff_ffff);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_MOVE, 4'b0001, 0, 0, 16'hffff);
    push(fcam_pkg::OP_MOVE, 4'b0011, 0, 0, 16'hffff);
    push(fcam_pkg::OP_MOVE, 4'b1100, 0, 0, 30000);
    push(fcam_pkg::OP_MOVE, 4'b1111, 0, 0, 0);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_TURN, 4'b1111, 32767, 32767, 16'hffff);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_TURN, 4'b0000, -32768, -32768, 16'hffff);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_LOAD, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_MOVE, 4'b0101, 0, 0, 16'hffff);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    push(fcam_pkg::OP_TURN, 4'b0000, 1600, -800, 65535);
    push(fcam_pkg::OP_MOVE, 4'b1010, 0, 0, 40000);
    push(fcam_pkg::OP_VIEW, 4'b0000, 0, 0, 0);
    drain();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(fcam_pkg::CFG_MOVE_SPEED, 32'hffff);
          write_reg(fcam_pkg::CFG_TURN_SPEED, 32'hffff);
          write_reg(fcam_pkg::CFG_START_X, 32'h8000_0000);
          write_reg(fcam_pkg::CFG_START_Y, 32'h7fff_ffff);
          write_reg(fcam_pkg::CFG_START_Z, 32'h8000_0000);
          write_reg(fcam_pkg::CFG_START_YAW, 32'hff4c_0000);
          write_reg(fcam_pkg::CFG_START_PITCH, 32'hffa6_0000);
        end
        1: begin
          write_reg(fcam_pkg::CFG_MOVE_SPEED, 32'h0);
          write_reg(fcam_pkg::CFG_TURN_SPEED, 32'h0);
        end
        default: begin
          for (int i = 0; i < 7; i++) write_reg(3'(i), $urandom);
          write_reg(fcam_pkg::CFG_MOVE_SPEED, $urandom_range(0, 4096));
          write_reg(fcam_pkg::CFG_TURN_SPEED, $urandom_range(0, 2048));
        end
      endcase
      if (p == 5) calm = 1'b1;
      push(fcam_pkg::OP_LOAD, 4'b0000, 0, 0, 0);
      push_random(p == 1 ? 30 : 60);
      if (p == 2) begin
        repeat (20) @(posedge clk);
        long_stall_go = 1'b1;
      end
      drain();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fcam_pkg.sv
rtl/fcam_mul.sv
rtl/fcam_cordic.sv
rtl/fly_camera_pose_and_view_matrix_core.sv
sim/tb_top.sv
